[design/wnp_pkg.sv]
// Shared types and constants of the window nearest point / RMSE block.
// No dependencies; the divider, root and top-level design files import it.
package wnp_pkg;

   localparam int RING_DEPTH_DEF = 256;
   localparam int COORD_W        = 32;
   localparam int SQ_W           = 64;
   localparam int WL_W           = 9;
   localparam int PADDR_W        = 3;

   localparam logic [WL_W-1:0] WINDOW_RESET = 9'd150;

   // register index as decoded from paddr[2]
   localparam logic CSR_WINDOW_LENGTH = 1'b0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_ERR,
      S_ERRW,
      S_SQD,
      S_DIVX,
      S_SQX,
      S_DIVY,
      S_SQY
   } state_type;

endpackage

[design/wnp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wnp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/wnp_div.sv]
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on wnp_pkg.
module wnp_div
   import wnp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_W-1:0]      dividend,
   input  logic [COORD_W-1:0]   divisor,
   output logic                 done,
   output logic [SQ_W-1:0]      quotient
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [$clog2(SQ_W)-1:0]    cnt_ff;
   logic [SQ_W-1:0]            q_ff;
   logic [COORD_W-1:0]         rem_ff;
   logic [COORD_W-1:0]         d_ff;
   logic [COORD_W:0]           trial;
   logic                       ge;

   assign trial = {rem_ff, q_ff[SQ_W-1]};
   assign ge    = (trial >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[SQ_W-2:0], ge};
         rem_ff <= ge ? COORD_W'(trial - {1'b0, d_ff}) : trial[COORD_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[design/wnp_sqrt.sv]
// Digit-by-digit floor square root of a 64-bit value, one result bit per cycle.
// Depends on wnp_pkg.
module wnp_sqrt
   import wnp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_W-1:0]      radicand,
   output logic                 done,
   output logic [COORD_W-1:0]   root
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [$clog2(COORD_W)-1:0]   cnt_ff;
   logic [SQ_W-1:0]              v_ff;
   logic [COORD_W-1:0]           res_ff;
   logic [COORD_W+1:0]           rem_ff;
   logic [COORD_W+2:0]           rem2;
   logic [COORD_W+2:0]           trial;
   logic                         ge;

   assign rem2  = {rem_ff[COORD_W:0], v_ff[SQ_W-1:SQ_W-2]};
   assign trial = {1'b0, res_ff, 2'b01};
   assign ge    = (rem2 >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         v_ff   <= {v_ff[SQ_W-3:0], 2'b00};
         res_ff <= {res_ff[COORD_W-2:0], ge};
         rem_ff <= ge ? (COORD_W+2)'(rem2 - trial) : rem2[COORD_W+1:0];
      end
   end

   assign done = done_ff;
   assign root = res_ff;

endmodule

[design/window_nearest_point_rmse.sv]
// Nearest stored point search over a sliding window with running RMSE.
// Push: busy stays low, no result. Evaluate: scan of the window (one ring read per cycle
// over the stored points in the window), the match error, the distance root, then the
// RMSE divide and root for x and then for y; busy drops in the cycle of the result strobe,
// and the receiver cannot stall.
// Synchronous reset clears pointers, counts, sums, state and window_length (150).
module window_nearest_point_rmse
   import wnp_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // input item transfer
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_mode,
   input  logic signed [COORD_W-1:0]  req_point_x,
   input  logic signed [COORD_W-1:0]  req_point_y,
   // result transfer
   output logic                       rsp_valid,
   output logic [COORD_W-1:0]         rsp_distance,
   output logic signed [COORD_W-1:0]  rsp_match_x,
   output logic signed [COORD_W-1:0]  rsp_match_y,
   output logic [COORD_W-1:0]         rsp_rmse_x,
   output logic [COORD_W-1:0]         rsp_rmse_y,
   output logic                       rsp_window_empty,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int LW = (CW > WL_W) ? CW : WL_W;
   localparam int SW = CW + 1;

   // ---------------- configuration ----------------
   logic [WL_W-1:0] wl_ff;
   logic            cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;
   assign prdata = (paddr[2] == CSR_WINDOW_LENGTH) ? {{(32-WL_W){1'b0}}, wl_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WINDOW_RESET;
      end else if (cfg_wr && paddr[2] == CSR_WINDOW_LENGTH) begin
         wl_ff <= pwdata[WL_W-1:0];
      end
   end

   // ---------------- control state ----------------
   state_type       state_ff, state_in;
   logic            accept;
   logic            push;
   logic            eval;
   logic [AW-1:0]   wp_ff;
   logic [CW-1:0]   fill_ff;
   logic [CW-1:0]   n_ff;
   logic [CW-1:0]   cnt_ff;
   logic [AW-1:0]   rd_idx_ff;
   logic            issue;
   logic            v0_ff, v1_ff, v2_ff;
   logic            err_go;

   assign accept = start & ~busy;
   assign push   = accept & ~req_mode;
   assign eval   = accept & req_mode;
   assign busy   = (state_ff != S_IDLE);

   // window clamp: zero reads as one, above the ring depth as the depth
   logic [LW-1:0] win;
   logic [CW-1:0] n_in;
   logic [SW-1:0] start_sum;
   logic [AW-1:0] start_idx;

   always_comb begin
      win = LW'(wl_ff);
      if (win == '0) begin
         win = LW'(1);
      end else if (win > LW'(RING_DEPTH)) begin
         win = LW'(RING_DEPTH);
      end
      n_in = (LW'(fill_ff) < win) ? fill_ff : win[CW-1:0];
      start_sum = SW'(wp_ff) + SW'(RING_DEPTH) - SW'(n_in);
      if (start_sum >= SW'(RING_DEPTH)) begin
         start_sum = start_sum - SW'(RING_DEPTH);
      end
      start_idx = start_sum[AW-1:0];
   end

   // ---------------- point ring ----------------
   logic [2*COORD_W-1:0] rdata;

   wnp_ram #(
      .WIDTH (2*COORD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (push),
      .waddr (wp_ff),
      .wdata ({req_point_y, req_point_x}),
      .re    (issue),
      .raddr (rd_idx_ff),
      .rdata (rdata)
   );

   assign issue  = (state_ff == S_SCAN) && (cnt_ff != n_ff);
   assign err_go = (state_ff == S_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (push) begin
         wp_ff <= (wp_ff == AW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff != CW'(RING_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // ---------------- distance pipeline ----------------
   // stage A: absolute differences; stage B: squares; stage C: compare or accumulate
   logic signed [COORD_W-1:0] fx_ff, fy_ff;
   logic [2*COORD_W-1:0]      src_pt;
   logic [COORD_W:0]          dx, dy;
   logic [COORD_W-1:0]        ax_ff, ay_ff;
   logic [2*COORD_W-1:0]      pa_ff, pb_ff;
   logic [SQ_W-1:0]           sx_ff, sy_ff;
   logic [SQ_W:0]             lo;
   logic [SQ_W:0]             best_ff;
   logic                      found_ff;
   logic [COORD_W-1:0]        best_x_ff, best_y_ff;

   assign src_pt = err_go ? {best_y_ff, best_x_ff} : rdata;
   assign dx = {fx_ff[COORD_W-1], fx_ff} - {src_pt[COORD_W-1], src_pt[COORD_W-1:0]};
   assign dy = {fy_ff[COORD_W-1], fy_ff}
             - {src_pt[2*COORD_W-1], src_pt[2*COORD_W-1:COORD_W]};
   assign lo = {1'b0, sx_ff} + {1'b0, sy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= issue;
         v1_ff <= v0_ff | err_go;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ay_ff <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      pa_ff <= src_pt;
      sx_ff <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sy_ff <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
      pb_ff <= pa_ff;
   end

   // ---------------- accumulators ----------------
   logic [SQ_W-1:0]    sum_x_ff, sum_y_ff;
   logic [COORD_W-1:0] count_ff;
   logic [SQ_W:0]      acc_x, acc_y;

   assign acc_x = {1'b0, sum_x_ff} + {1'b0, sx_ff};
   assign acc_y = {1'b0, sum_y_ff} + {1'b0, sy_ff};

   // ---------------- divide and root units ----------------
   logic               div_start, div_done;
   logic [SQ_W-1:0]    div_q;
   logic               sq_start, sq_done;
   logic [SQ_W-1:0]    sq_rad;
   logic [COORD_W-1:0] sq_root;

   wnp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == S_SQD) ? sum_x_ff : sum_y_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sq_rad = (state_ff == S_ERRW) ? best_ff[SQ_W-1:0] : div_q;

   wnp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      sq_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (eval) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!issue && !v0_ff && !v1_ff && !v2_ff) state_in = S_ERR;
         end
         S_ERR: begin
            state_in = S_ERRW;
         end
         S_ERRW: begin
            if (v2_ff) begin
               sq_start = 1'b1;
               state_in = S_SQD;
            end
         end
         S_SQD: begin
            if (sq_done) begin
               div_start = 1'b1;
               state_in  = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_done) begin
               sq_start = 1'b1;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            if (sq_done) begin
               div_start = 1'b1;
               state_in  = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done) begin
               sq_start = 1'b1;
               state_in = S_SQY;
            end
         end
         S_SQY: begin
            if (sq_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan bookkeeping, best match and sums
   logic rsp_valid_ff;
   logic [COORD_W-1:0] dist_ff, rmse_x_ff, rmse_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         n_ff         <= '0;
         rd_idx_ff    <= '0;
         found_ff     <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (eval) begin
            // latch the filtered point and the window, clear the match
            fx_ff     <= req_point_x;
            fy_ff     <= req_point_y;
            n_ff      <= n_in;
            cnt_ff    <= '0;
            rd_idx_ff <= start_idx;
            found_ff  <= 1'b0;
            best_ff   <= '0;
            best_x_ff <= '0;
            best_y_ff <= '0;
         end
         if (issue) begin
            cnt_ff    <= cnt_ff + 1'b1;
            rd_idx_ff <= (rd_idx_ff == AW'(RING_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
         end
         // strictly smaller wins, so ties keep the oldest
         if (state_ff == S_SCAN && v2_ff && (!found_ff || lo < best_ff)) begin
            found_ff  <= 1'b1;
            best_ff   <= lo;
            best_x_ff <= pb_ff[COORD_W-1:0];
            best_y_ff <= pb_ff[2*COORD_W-1:COORD_W];
         end
         // accumulate the match error with saturation
         if (state_ff == S_ERRW && v2_ff) begin
            sum_x_ff <= acc_x[SQ_W] ? '1 : acc_x[SQ_W-1:0];
            sum_y_ff <= acc_y[SQ_W] ? '1 : acc_y[SQ_W-1:0];
            if (count_ff != '1) count_ff <= count_ff + 1'b1;
         end
         if (state_ff == S_SQD && sq_done) begin
            dist_ff <= (!found_ff || best_ff[SQ_W]) ? '1 : sq_root;
         end
         if (state_ff == S_SQX && sq_done) begin
            rmse_x_ff <= sq_root;
         end
         if (state_ff == S_SQY && sq_done) begin
            rmse_y_ff    <= sq_root;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = dist_ff;
   assign rsp_match_x      = best_x_ff;
   assign rsp_match_y      = best_y_ff;
   assign rsp_rmse_x       = rmse_x_ff;
   assign rsp_rmse_y       = rmse_y_ff;
   assign rsp_window_empty = ~found_ff;

   // ---------------- assertions ----------------
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode) |=> busy)
      else $error("evaluate transfer did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_empty_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_empty) |->
         (rsp_distance == '1 && rsp_match_x == '0 && rsp_match_y == '0))
      else $error("empty window result malformed");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(RING_DEPTH))
      else $error("fill count beyond ring depth");

endmodule

[tb/sv/tb_window_nearest_point_rmse.sv]
// Testbench for window_nearest_point_rmse: drives push/evaluate transfers and
// the APB window_length register, and checks every result against a predictor.
// Depends on wnp_pkg and the window_nearest_point_rmse top level.
`timescale 1ns / 1ps

module tb_window_nearest_point_rmse;
   import wnp_pkg::*;

   localparam int DEPTH = RING_DEPTH_DEF;

   typedef struct {
      logic [31:0]        distance;
      logic signed [31:0] match_x;
      logic signed [31:0] match_y;
      logic [31:0]        rmse_x;
      logic [31:0]        rmse_y;
      logic               window_empty;
   } match_result_type;

   // Tracks the ring, running sums and window setting; holds pending results.
   class nearest_point_board;
      logic [63:0]      ring [DEPTH];
      int unsigned      wr_ptr;
      int unsigned      fill;
      logic [63:0]      sum_x;
      logic [63:0]      sum_y;
      logic [31:0]      evals;
      logic [8:0]       win_len;
      match_result_type pending [$];
      int               errors;

      function new();
         wr_ptr  = 0;
         fill    = 0;
         sum_x   = 0;
         sum_y   = 0;
         evals   = 0;
         win_len = WINDOW_RESET;
         errors  = 0;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      function void set_window(logic [8:0] v);
         win_len = v;
      endfunction

      static function logic [63:0] floor_sqrt(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      static function logic [63:0] err_sq(logic signed [31:0] a, logic signed [31:0] b);
         longint d;
         logic [63:0] m;
         d = longint'(a) - longint'(b);
         m = (d < 0) ? -d : d;
         return m * m;
      endfunction

      static function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
         logic [64:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[64] ? '1 : s[63:0];
      endfunction

      // Note an accepted input transfer; an evaluate queues one result.
      function void note_input(logic mode, logic signed [31:0] px, logic signed [31:0] py);
         int unsigned win, n, idx;
         logic [64:0] best, tot;
         logic signed [31:0] mx, my;
         logic found;
         match_result_type r;
         if (mode == 1'b0) begin
            ring[wr_ptr] = {py, px};
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (fill < DEPTH) fill++;
            return;
         end
         win = (win_len == 0) ? 1 : win_len;
         if (win > DEPTH) win = DEPTH;
         n = (fill < win) ? fill : win;
         found = 0;
         best  = 0;
         mx    = 0;
         my    = 0;
         // oldest to newest, strict improvement only, so ties keep the oldest
         for (int unsigned i = 0; i < n; i++) begin
            idx = (wr_ptr + DEPTH - n + i) % DEPTH;
            tot = {1'b0, err_sq(px, ring[idx][31:0])} + {1'b0, err_sq(py, ring[idx][63:32])};
            if (!found || tot < best) begin
               found = 1;
               best  = tot;
               mx    = ring[idx][31:0];
               my    = ring[idx][63:32];
            end
         end
         if (!found || best[64]) r.distance = '1;
         else r.distance = 32'(floor_sqrt(best[63:0]));
         sum_x = sat_sum(sum_x, err_sq(px, mx));
         sum_y = sat_sum(sum_y, err_sq(py, my));
         if (evals != 32'hFFFF_FFFF) evals++;
         r.match_x      = mx;
         r.match_y      = my;
         r.rmse_x       = 32'(floor_sqrt(sum_x / evals));
         r.rmse_y       = 32'(floor_sqrt(sum_y / evals));
         r.window_empty = !found;
         pending.push_back(r);
      endfunction

      task check_result(match_result_type got);
         match_result_type e;
         if (pending.size() == 0) begin
            report("result with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (got.distance !== e.distance)
            report($sformatf("distance %h, expected %h", got.distance, e.distance));
         if (got.match_x !== e.match_x)
            report($sformatf("match_x %h, expected %h", got.match_x, e.match_x));
         if (got.match_y !== e.match_y)
            report($sformatf("match_y %h, expected %h", got.match_y, e.match_y));
         if (got.rmse_x !== e.rmse_x)
            report($sformatf("rmse_x %h, expected %h", got.rmse_x, e.rmse_x));
         if (got.rmse_y !== e.rmse_y)
            report($sformatf("rmse_y %h, expected %h", got.rmse_y, e.rmse_y));
         if (got.window_empty !== e.window_empty)
            report($sformatf("window_empty %b, expected %b", got.window_empty, e.window_empty));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_mode;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic                      rsp_valid;
   logic [COORD_W-1:0]        rsp_distance;
   logic signed [COORD_W-1:0] rsp_match_x;
   logic signed [COORD_W-1:0] rsp_match_y;
   logic [COORD_W-1:0]        rsp_rmse_x;
   logic [COORD_W-1:0]        rsp_rmse_y;
   logic                      rsp_window_empty;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [PADDR_W-1:0]        paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   nearest_point_board board;
   bit   idle_on;      // random sender gaps enabled
   int   pushes;
   int   evaluates;
   int   csr_writes;

   window_nearest_point_rmse u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_distance     (rsp_distance),
      .rsp_match_x      (rsp_match_x),
      .rsp_match_y      (rsp_match_y),
      .rsp_rmse_x       (rsp_rmse_x),
      .rsp_rmse_y       (rsp_rmse_y),
      .rsp_window_empty (rsp_window_empty),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Results last exactly one cycle and cannot be stalled: sample every edge.
   always @(posedge clock) begin
      match_result_type got;
      if (!reset && rsp_valid) begin
         got.distance     = rsp_distance;
         got.match_x      = rsp_match_x;
         got.match_y      = rsp_match_y;
         got.rmse_x       = rsp_rmse_x;
         got.rmse_y       = rsp_rmse_y;
         got.window_empty = rsp_window_empty;
         board.check_result(got);
      end
   end

   // Issue one item. Start is lowered only across a gap, so a back-to-back
   // transfer never sees start dropped and raised in the same step.
   task send_item(logic mode, logic signed [31:0] px, logic signed [31:0] py);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 35) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_mode    <= mode;
      req_point_x <= px;
      req_point_y <= py;
      // hold until the edge where busy is low completes the transfer
      do @(posedge clock); while (busy);
      board.note_input(mode, px, py);
      if (mode) evaluates++;
      else pushes++;
   endtask

   // Drain: wait for every expected result, then let trailing work settle.
   task wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task csr_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // only index 0 exists; other addresses are ignored by the block
      if (addr[PADDR_W-1:2] == 0) board.set_window(data[8:0]);
      csr_writes++;
      @(posedge clock);
   endtask

   task csr_check_window();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[8:0] !== board.win_len)
         board.report($sformatf("window_length read %h, expected %h",
                                prdata[8:0], board.win_len));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain, then reprogram the window and read it back.
   task set_window(logic [31:0] v);
      wait_drained();
      csr_write({CSR_WINDOW_LENGTH, 2'b00}, v);
      csr_check_window();
   endtask

   // Mostly small coordinates keep the running sums out of saturation;
   // arithmetic shift of a full random word still toggles every bit.
   function automatic logic signed [31:0] rand_coord(bit full);
      logic signed [31:0] v;
      v = $urandom;
      if (!full) v = v >>> $urandom_range(8, 22);
      return v;
   endfunction

   initial begin
      logic signed [31:0] cx, cy;
      board       = new();
      idle_on     = 1'b1;
      pushes      = 0;
      evaluates   = 0;
      csr_writes  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_mode    = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty window, ties, exact hit, short and clamped windows.
      csr_check_window();
      send_item(1'b1, 32'sd5 <<< 16, -(32'sd3 <<< 16));
      send_item(1'b0, 32'sd1 <<< 16, 32'sd2 <<< 16);
      send_item(1'b0, 32'sd1 <<< 16, 32'sd2 <<< 16);       // duplicate point
      send_item(1'b0, -(32'sd1 <<< 16), -(32'sd2 <<< 16)); // same distance
      send_item(1'b0, -(32'sd2 <<< 16), 32'sd1 <<< 16);
      send_item(1'b1, 32'sd0, 32'sd0);                     // tie keeps oldest
      send_item(1'b1, -(32'sd2 <<< 16), 32'sd1 <<< 16);   // exact match
      send_item(1'b1, 32'sd3, -32'sd7);
      set_window(32'd1);
      send_item(1'b1, 32'sd0, 32'sd0);                     // newest only
      set_window(32'd0);                                   // zero acts as one
      send_item(1'b1, 32'sd1 <<< 16, 32'sd2 <<< 16);
      wait_drained();
      csr_write(3'd4, 32'd77);                             // no such register
      csr_check_window();
      set_window(32'h1FF);                                 // clamps to depth
      send_item(1'b1, 32'sd100, -32'sd100);
      set_window(32'd2);
      send_item(1'b1, 32'sd1 <<< 16, 32'sd2 <<< 16);

      // Random: well-formed push/evaluate mixes, window changed per phase.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_window(32'd150);
            1: set_window(32'd256);
            2: set_window(32'd5);
            3: set_window(32'h1FF);
            4: set_window($urandom_range(1, 255));
            default: set_window(32'd0);
         endcase
         for (int k = 0; k < 90; k++) begin
            idle_on = !(ph == 2);      // one phase runs with no gaps at all
            if (ph == 1 && k == 45) wait_drained();  // sender holds off
            if ($urandom_range(0, 99) < 55) begin
               send_item(1'b0, rand_coord($urandom_range(0, 19) == 0),
                         rand_coord($urandom_range(0, 19) == 0));
            end else begin
               cx = rand_coord(1'b0);
               cy = rand_coord(1'b0);
               send_item(1'b1, cx, cy);
            end
         end
      end
      idle_on = 1'b1;

      // Extremes last: overflowing distance and sticky saturated sums.
      set_window(32'd1);
      send_item(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_item(1'b1, 32'sh8000_0000, 32'sh8000_0000);
      send_item(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_item(1'b0, 32'sh8000_0000, 32'sh8000_0000);
      send_item(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_item(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      for (int k = 0; k < 12; k++)
         send_item(1'($urandom_range(0, 1)), rand_coord(1'b1), rand_coord(1'b1));

      wait_drained();
      repeat (300) @(posedge clock);
      $display("Covered %0d pushes and %0d evaluates over %0d register writes,",
               pushes, evaluates, csr_writes);
      $display("including empty, tied, clamped and saturating cases.");
      if (board.pending.size() != 0)
         board.report($sformatf("%0d results never arrived", board.pending.size()));
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Bound the run well beyond the slowest legal completion.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
design/wnp_pkg.sv
design/wnp_ram.sv
design/wnp_div.sv
design/wnp_sqrt.sv
design/window_nearest_point_rmse.sv
tb/sv/tb_window_nearest_point_rmse.sv
